// ----- rtl/gra_pkg.sv -----
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types and constants for the gyro rate angle integrator: register
// indexes and reset values, sequencer states and the control word.
// ----------------------------------------------------------------------------
package gra_pkg;

	localparam int RATE_BITS_DEF = 16;

	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 16;
	localparam int BAND_W     = 15;
	localparam int FRAC_BITS  = 16;

	localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEADBAND = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SCALE    = 3'd5;

	localparam logic [15:0]       X_OFFSET_RST = 16'd210;
	localparam logic [15:0]       Y_OFFSET_RST = 16'd675;
	localparam logic [BAND_W-1:0] DEADBAND_RST = 15'd100;
	localparam logic [15:0]       X_STEP_RST   = 16'd4306;
	localparam logic [15:0]       Y_STEP_RST   = 16'd4325;
	localparam logic [15:0]       SCALE_RST    = 16'd573;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SCL_X,
		ST_SCL_Y,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		MS_AVG_X,
		MS_AVG_Y,
		MS_ACC_X,
		MS_ACC_Y
	} mul_src_t;

	typedef struct packed {
		logic     prep_en;
		logic     mul_en;
		mul_src_t mul_src;
		logic     acc_x_en;
		logic     acc_y_en;
		logic     pan_en;
		logic     fin;
	} ctrl_t;

endpackage

// ----- rtl/gra_axis.sv -----
// ----------------------------------------------------------------------------
// gra_axis
// Per-axis rate conditioning: offset removal with saturation, deadband and
// averaging with the previous corrected rate (halved toward zero).
// ----------------------------------------------------------------------------
module gra_axis #(
	parameter int RATE_BITS = gra_pkg::RATE_BITS_DEF
) (
	input  logic signed [15:0]               raw,
	input  logic signed [15:0]               offset,
	input  logic [gra_pkg::BAND_W-1:0]       deadband,
	input  logic signed [RATE_BITS-1:0]      prev,
	output logic signed [RATE_BITS-1:0]      rate,
	output logic signed [RATE_BITS-1:0]      avg
);

	localparam int EW = (RATE_BITS > 17) ? RATE_BITS : 17;
	localparam int CW = (RATE_BITS > gra_pkg::BAND_W) ? RATE_BITS : gra_pkg::BAND_W;
	localparam longint HI_L = (64'sd1 <<< (RATE_BITS - 1)) - 64'sd1;
	localparam logic signed [EW-1:0] HI = EW'(HI_L);
	localparam logic signed [EW-1:0] LO = EW'(-HI_L - 64'sd1);

	logic signed [16:0]          diff;
	logic signed [EW-1:0]        diff_e;
	logic signed [EW-1:0]        sat_e;
	logic signed [RATE_BITS-1:0] sat;
	logic [RATE_BITS-1:0]        mag;
	logic signed [RATE_BITS:0]   sum;
	logic signed [RATE_BITS:0]   sum_adj;

	assign diff   = 17'(raw) - 17'(offset);
	assign diff_e = EW'(diff);

	always_comb begin
		if (diff_e > HI) begin
			sat_e = HI;
		end else if (diff_e < LO) begin
			sat_e = LO;
		end else begin
			sat_e = diff_e;
		end
	end

	assign sat  = sat_e[RATE_BITS-1:0];
	assign mag  = sat[RATE_BITS-1] ? (~sat + 1'b1) : sat;
	assign rate = (CW'(mag) < CW'(deadband)) ? '0 : sat;

	// halve toward zero
	assign sum     = (RATE_BITS+1)'(prev) + (RATE_BITS+1)'(rate);
	assign sum_adj = sum + (RATE_BITS+1)'(sum[RATE_BITS]);
	assign avg     = sum_adj[RATE_BITS:1];

endmodule

// ----- rtl/gra_mul.sv -----
// ----------------------------------------------------------------------------
// gra_mul
// Shared signed by unsigned Q0.16 multiplier with registered product; the
// output is the product divided by 65536 toward zero, low 16 bits.
// ----------------------------------------------------------------------------
module gra_mul #(
	parameter int AW = gra_pkg::RATE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic [15:0]          b,
	output logic [15:0]          q
);

	localparam int PW = AW + 17;

	logic signed [PW-1:0] prod_q;
	logic [PW-1:0]        adj;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * $signed({1'b0, b});
		end
	end

	assign adj = prod_q + (prod_q[PW-1] ? PW'(17'h0FFFF) : '0);
	assign q   = adj[gra_pkg::FRAC_BITS +: 16];

endmodule

// ----- rtl/gyro_rate_angle_integrator_core.sv -----
// ----------------------------------------------------------------------------
// gyro_rate_angle_integrator_core
// Two-axis gyro rate to angle integrator with a single shared multiplier.
// ----------------------------------------------------------------------------
// Each accepted item (rate_x, rate_y) yields one result (pan_angle,
// tilt_angle): the PREP state conditions both rates, then one multiplier
// is used four times in a row (x step, y step, x scale, y scale) and a
// final state, FIN, loads the output register. A new item is taken in the
// idle state that follows the load, so the block does not take a new item
// before it is through with the last one; the pace is set by the six
// sequencer steps plus the idle state in which the item is taken, slower
// while the output register still holds an unaccepted result. The output
// register holds a finished result while the next item is being processed.
// Configuration writes take effect at once and should only be issued idle.
// ----------------------------------------------------------------------------
module gyro_rate_angle_integrator_core #(
	parameter int RATE_BITS = gra_pkg::RATE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                rate_x,
	input  logic signed [15:0]                rate_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                pan_angle,
	output logic signed [15:0]                tilt_angle,
	input  logic                              wr_en,
	input  logic [gra_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [gra_pkg::REG_DATA_W-1:0]    wr_data
);

	localparam int AW = (RATE_BITS > 16) ? RATE_BITS : 16;

	gra_pkg::state_t state_q, state_d;
	gra_pkg::ctrl_t  ctrl;

	logic signed [15:0]             x_offset_q, y_offset_q;
	logic [gra_pkg::BAND_W-1:0]     deadband_q;
	logic [15:0]                    x_step_q, y_step_q, scale_q;

	logic signed [15:0]             raw_x_q, raw_y_q;
	logic signed [RATE_BITS-1:0]    prev_x_q, prev_y_q;
	logic signed [RATE_BITS-1:0]    avg_x_q, avg_y_q;
	logic signed [RATE_BITS-1:0]    rate_xc, rate_yc, avg_xc, avg_yc;
	logic signed [15:0]             acc_x_q, acc_y_q;
	logic signed [15:0]             pan_q;
	logic signed [15:0]             pan_angle_q, tilt_angle_q;
	logic                           out_valid_q;
	logic                           out_free;

	logic signed [AW-1:0]           mul_a;
	logic [15:0]                    mul_b;
	logic [15:0]                    mul_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= gra_pkg::X_OFFSET_RST;
			y_offset_q <= gra_pkg::Y_OFFSET_RST;
			deadband_q <= gra_pkg::DEADBAND_RST;
			x_step_q   <= gra_pkg::X_STEP_RST;
			y_step_q   <= gra_pkg::Y_STEP_RST;
			scale_q    <= gra_pkg::SCALE_RST;
		end else if (wr_en) begin
			case (wr_index)
				gra_pkg::REG_X_OFFSET: x_offset_q <= wr_data;
				gra_pkg::REG_Y_OFFSET: y_offset_q <= wr_data;
				gra_pkg::REG_DEADBAND: deadband_q <= wr_data[gra_pkg::BAND_W-1:0];
				gra_pkg::REG_X_STEP:   x_step_q   <= wr_data;
				gra_pkg::REG_Y_STEP:   y_step_q   <= wr_data;
				gra_pkg::REG_SCALE:    scale_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == gra_pkg::ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gra_pkg::ST_IDLE:  if (in_valid) state_d = gra_pkg::ST_PREP;
			gra_pkg::ST_PREP:  state_d = gra_pkg::ST_MUL_X;
			gra_pkg::ST_MUL_X: state_d = gra_pkg::ST_MUL_Y;
			gra_pkg::ST_MUL_Y: state_d = gra_pkg::ST_SCL_X;
			gra_pkg::ST_SCL_X: state_d = gra_pkg::ST_SCL_Y;
			gra_pkg::ST_SCL_Y: state_d = gra_pkg::ST_FIN;
			gra_pkg::ST_FIN:   if (out_free) state_d = gra_pkg::ST_IDLE;
			default:           state_d = gra_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_src = gra_pkg::MS_AVG_X;
		case (state_q)
			gra_pkg::ST_PREP: ctrl.prep_en = 1'b1;
			gra_pkg::ST_MUL_X: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_src = gra_pkg::MS_AVG_X;
			end
			gra_pkg::ST_MUL_Y: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_src  = gra_pkg::MS_AVG_Y;
				ctrl.acc_x_en = 1'b1;
			end
			gra_pkg::ST_SCL_X: begin
				ctrl.mul_en   = 1'b1;
				ctrl.mul_src  = gra_pkg::MS_ACC_X;
				ctrl.acc_y_en = 1'b1;
			end
			gra_pkg::ST_SCL_Y: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_src = gra_pkg::MS_ACC_Y;
				ctrl.pan_en  = 1'b1;
			end
			gra_pkg::ST_FIN: ctrl.fin = out_free;
			default: ;
		endcase
	end

	// rate conditioning lanes
	gra_axis #(.RATE_BITS(RATE_BITS)) u_axis_x (
		.raw      (raw_x_q),
		.offset   (x_offset_q),
		.deadband (deadband_q),
		.prev     (prev_x_q),
		.rate     (rate_xc),
		.avg      (avg_xc)
	);

	gra_axis #(.RATE_BITS(RATE_BITS)) u_axis_y (
		.raw      (raw_y_q),
		.offset   (y_offset_q),
		.deadband (deadband_q),
		.prev     (prev_y_q),
		.rate     (rate_yc),
		.avg      (avg_yc)
	);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_x_q <= rate_x;
			raw_y_q <= rate_y;
		end
		if (ctrl.prep_en) begin
			avg_x_q <= avg_xc;
			avg_y_q <= avg_yc;
		end
		if (ctrl.pan_en) begin
			pan_q <= mul_q;
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (ctrl.mul_src)
			gra_pkg::MS_AVG_X: begin
				mul_a = AW'(avg_x_q);
				mul_b = x_step_q;
			end
			gra_pkg::MS_AVG_Y: begin
				mul_a = AW'(avg_y_q);
				mul_b = y_step_q;
			end
			gra_pkg::MS_ACC_X: begin
				mul_a = AW'(acc_x_q);
				mul_b = scale_q;
			end
			gra_pkg::MS_ACC_Y: begin
				mul_a = AW'(acc_y_q);
				mul_b = scale_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	gra_mul #(.AW(AW)) u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_q)
	);

	// integrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
		end else begin
			if (ctrl.prep_en) begin
				prev_x_q <= rate_xc;
				prev_y_q <= rate_yc;
			end
			if (ctrl.acc_x_en) begin
				acc_x_q <= acc_x_q + mul_q;
			end
			if (ctrl.acc_y_en) begin
				acc_y_q <= acc_y_q + mul_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			pan_angle_q  <= pan_q;
			tilt_angle_q <= mul_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign pan_angle  = pan_angle_q;
	assign tilt_angle = tilt_angle_q;

	a_acc_x_only_after_mul_y: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(acc_x_q) |-> $past(state_q) == gra_pkg::ST_MUL_Y)
		else $error("x accumulator changed outside its update slot");

	a_accept_starts_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == gra_pkg::ST_PREP)
		else $error("accepted item did not start conditioning");

	a_fin_waits_for_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gra_pkg::ST_FIN && out_valid_q && !out_ready |=> state_q == gra_pkg::ST_FIN)
		else $error("result dropped while output slot busy");

	a_scale_y_then_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gra_pkg::ST_SCL_Y |=> state_q == gra_pkg::ST_FIN)
		else $error("sequencer skipped the final cycle");

endmodule
